>>> design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Default ring capacity and the fixed width of the reported count
  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned CountW       = 5;
  localparam int unsigned DataW        = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_type_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } ctrl_state_e;

  // Request payload
  typedef struct packed {
    req_type_e                 req_type;
    logic signed [DataW-1:0]   push_value;
  } deq_req_t;

  // Result payload
  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   removed_value;
    logic [CountW-1:0]         entry_count;
  } deq_rsp_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

endpackage

>>> design/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output deq_pkg::ctrl_cmd_t   cmd_o
);

  deq_pkg::ctrl_state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (start) begin
          state_d = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: state_d = deq_pkg::S_RESP;
      deq_pkg::S_RESP: state_d = deq_pkg::S_IDLE;
      default:         state_d = deq_pkg::S_IDLE;
    endcase
  end

  // Drive commands and busy
  always_comb begin
    busy          = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.respond = 1'b0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      deq_pkg::S_EXEC: cmd_o.exec    = 1'b1;
      deq_pkg::S_RESP: cmd_o.respond = 1'b1;
      default:         busy          = 1'b1;
    endcase
  end

endmodule

>>> design/deq_dp.sv
`timescale 1ns / 1ps

module deq_dp #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  deq_pkg::ctrl_cmd_t  cmd_i,
  input  deq_pkg::deq_req_t   req_i,
  output logic                done_o,
  output deq_pkg::deq_rsp_t   rsp_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  // Ring storage
  logic [deq_pkg::DataW-1:0] mem_q [DEPTH];

  deq_pkg::deq_req_t   req_q;
  logic [PtrW-1:0]     front_q, front_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [deq_pkg::DataW-1:0] rd_q;
  logic                pop_ok_q;
  deq_pkg::status_e    status_q, status_d;

  logic                is_push, full, empty, wr_en, rd_en;
  logic [PtrW-1:0]     front_dec, front_inc, tail_idx, addr;
  logic [CntW-1:0]     tail_off;
  logic [SumW-1:0]     tail_sum;

  // Hold the request for the execute cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Decode request and ring indexes
  always_comb begin
    is_push = (req_q.req_type == deq_pkg::REQ_PUSH_FRONT) ||
              (req_q.req_type == deq_pkg::REQ_PUSH_BACK);
    full    = (count_q == CntW'(DEPTH));
    empty   = (count_q == '0);

    front_dec = (front_q == '0) ? PtrW'(DEPTH - 1) : front_q - 1'b1;
    front_inc = (front_q == PtrW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

    tail_off = (req_q.req_type == deq_pkg::REQ_PUSH_BACK) ? count_q : count_q - 1'b1;
    tail_sum = SumW'(front_q) + SumW'(tail_off);
    if (tail_sum >= SumW'(DEPTH)) begin
      tail_sum = tail_sum - SumW'(DEPTH);
    end
    tail_idx = tail_sum[PtrW-1:0];
  end

  // Select address, status and pointer updates
  always_comb begin
    addr     = front_q;
    front_d  = front_q;
    count_d  = count_q;
    status_d = deq_pkg::ST_DONE;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    unique case (req_q.req_type)
      deq_pkg::REQ_PUSH_FRONT: addr = front_dec;
      deq_pkg::REQ_PUSH_BACK:  addr = tail_idx;
      deq_pkg::REQ_POP_FRONT:  addr = front_q;
      deq_pkg::REQ_POP_BACK:   addr = tail_idx;
      default:                 addr = front_q;
    endcase
    if (cmd_i.exec) begin
      if (is_push) begin
        if (full) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (req_q.req_type == deq_pkg::REQ_PUSH_FRONT) begin
            front_d = front_dec;
          end
        end
      end else begin
        if (empty) begin
          status_d = deq_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          count_d = count_q - 1'b1;
          if (req_q.req_type == deq_pkg::REQ_POP_FRONT) begin
            front_d = front_inc;
          end
        end
      end
    end
  end

  // Update pointer and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Hold the outcome of the execute cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= rd_en;
    end
  end

  // Write and read the ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= req_q.push_value;
    end
    if (rd_en) begin
      rd_q <= mem_q[addr];
    end
  end

  // Present the result
  always_comb begin
    done_o              = cmd_i.respond;
    rsp_o.status        = status_q;
    rsp_o.removed_value = pop_ok_q ? rd_q : '0;
    rsp_o.entry_count   = deq_pkg::CountW'(count_q);
  end

endmodule

>>> design/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a ring of
// DEPTH entries.
// Request channel: drive req_i and raise start; the request transfers at
// the rising edge where start is high and busy is low. req_type selects
// push front, push back, remove front or remove back.
// Result channel: done_o is high for exactly one cycle with rsp_o valid;
// the result transfers at the edge that ends that cycle. The receiver
// cannot stall, so the result is never held.
// Sequence: each request runs through the controller steps capture,
// execute (one ring memory port access: write on a push, registered read
// on a removal) and respond. busy stays high from the transfer until the
// result cycle ends, so no new request is taken before the last result.
// Status reports full on a push into a full queue and empty on a removal
// from an empty queue; the queue is left unchanged in both cases.
// Reset empties the queue (front pointer and count to zero); ring
// contents are not cleared and no entry is read before it was written.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  deq_pkg::deq_req_t  req_i,
  output logic               busy,
  output logic               done_o,
  output deq_pkg::deq_rsp_t  rsp_o
);

  deq_pkg::ctrl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

>>> tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH = DefaultDepth;
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_REQS = 1600;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  deq_req_t  req_i;
  logic      busy;
  logic      done_o;
  deq_rsp_t  rsp_o;

  // Mirror of the ring contents, front index and fill level
  logic [DataW-1:0] ring_mirror [DEPTH];
  int unsigned      mirror_front;
  int unsigned      mirror_fill;

  // Results owed by the block, oldest first
  deq_rsp_t    owed_results[$];
  int unsigned error_count;
  int unsigned quiet_cycles;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to the mirror and return the result it must produce
  function automatic deq_rsp_t apply_deq_request(deq_req_t r);
    deq_rsp_t    res;
    int unsigned slot;
    res.status        = ST_DONE;
    res.removed_value = '0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (mirror_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          mirror_front              = (mirror_front == 0) ? DEPTH - 1 : mirror_front - 1;
          ring_mirror[mirror_front] = r.push_value;
          mirror_fill++;
        end else begin
          slot              = (mirror_front + mirror_fill) % DEPTH;
          ring_mirror[slot] = r.push_value;
          mirror_fill++;
        end
      end
      default: begin
        if (mirror_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (r.req_type == REQ_POP_FRONT) begin
          res.removed_value = ring_mirror[mirror_front];
          mirror_front      = (mirror_front + 1) % DEPTH;
          mirror_fill--;
        end else begin
          slot              = (mirror_front + mirror_fill - 1) % DEPTH;
          res.removed_value = ring_mirror[slot];
          mirror_fill--;
        end
      end
    endcase
    res.entry_count = mirror_fill[CountW-1:0];
    return res;
  endfunction

  // Drive one request and hold it until the block takes the transfer
  task automatic send_request(req_type_e kind, logic [DataW-1:0] value);
    deq_req_t r;
    r.req_type   = kind;
    r.push_value = value;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    owed_results.push_back(apply_deq_request(r));
  endtask

  // Drop start for a number of cycles; call only right after a transfer
  task automatic hold_off(int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic report_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Check each result transfer against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_o);
        error_count++;
      end else begin
        report_field("status", 32'(owed_results[0].status), 32'(rsp_o.status));
        report_field("removed_value", owed_results[0].removed_value, rsp_o.removed_value);
        report_field("entry_count", 32'(owed_results[0].entry_count),
                     32'(rsp_o.entry_count));
        void'(owed_results.pop_front());
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, expected a transfer, actual none for %0d cycles",
                 $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Removals on an empty queue from both ends
  task automatic test_empty_removal();
    send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_POP_BACK, 32'h1234_5678);
  endtask

  // Extreme values through both ends, then drain to empty and one past
  task automatic test_both_ends();
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    hold_off(1);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_POP_FRONT, '0);
    hold_off(2);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
  endtask

  // Fill to capacity, then push at both ends into the full queue
  task automatic test_full_push();
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    end
    send_request(REQ_PUSH_FRONT, 32'h5555_5555);
    send_request(REQ_PUSH_BACK, 32'hAAAA_AAAA);
  endtask

  // Random traffic in phases that lean toward filling, draining or neither
  task automatic test_random_traffic();
    int unsigned burst_left;
    int unsigned lean;
    int unsigned push_pct;
    req_type_e   kind;
    burst_left = 0;
    lean       = 2;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) lean = $urandom_range(0, 2);
      push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
      if ($urandom_range(1, 100) <= push_pct) begin
        kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end
      send_request(kind, pick_value());
      // Vary gap length so idle cycles land on every controller phase
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 5))
          0:       hold_off(0);
          1:       hold_off($urandom_range(5, 12));
          default: hold_off($urandom_range(1, 4));
        endcase
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    error_count  = 0;
    quiet_cycles = 0;
    mirror_front = 0;
    mirror_fill  = 0;
    for (int i = 0; i < DEPTH; i++) ring_mirror[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_removal();
    test_both_ends();
    test_full_push();
    test_random_traffic();
    start <= 1'b0;

    // Drain owed results, then let the pipeline settle
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
